// ===== rtl/flr_pkg.sv =====
// Shared types, codes and constants of the flash stream recorder.
// No dependencies; every other rtl file refers to it by scoped names.
package flr_pkg;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_STOP  = 2'd2,
    FN_PUSH  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ERASE   = 3'd1,
    KIND_PROGRAM = 3'd2,
    KIND_STOPPED = 3'd3,
    KIND_VERDICT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_QUEUED        = 2'd0,
    VERDICT_NOT_RECORDING = 2'd1,
    VERDICT_QUEUE_FULL    = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    STATE_IDLE      = 2'd0,
    STATE_RECORDING = 2'd1,
    STATE_STOPPING  = 2'd2
  } state_code_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT   = 2'd1,
    PH_DECIDE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_SINGLE = 2'd1,
    BK_PAGE   = 2'd2
  } back_state_t;

  localparam logic [1:0] REG_FLASH_START = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd1;

  localparam int SUM_W = 26;
  localparam logic [SUM_W-1:0] BLOCK_BYTES = 26'd65536;
  localparam logic [SUM_W-1:0] PAGE_BYTES  = 26'd256;
  localparam logic [SUM_W-1:0] GUARD_BYTES = 26'd4096;
  localparam int KB_SHIFT = 10;
  localparam logic [24:0] ADDR_LIMIT      = 25'h1FFFFFF;
  localparam logic [24:0] MAX_BYTES_RESET = 25'd1048576;

  localparam int PAGE_WORDS = 64;
  localparam int WORD_IDX_W = 6;
  localparam int FILL_W     = 7;
  localparam logic [WORD_IDX_W-1:0] PAGE_LAST = 6'd63;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [23:0] flash_address;
    verdict_t    verdict;
    state_code_t state_code;
    logic [14:0] recorded_kb;
    logic [5:0]  queued_packets;
  } cmd_t;

  function automatic logic [24:0] sat_addr(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? ADDR_LIMIT : v[24:0];
  endfunction

endpackage

// ===== rtl/flr_cmd_fifo.sv =====
// Short request queue between the front and the back of the recorder.
// Depends on flr_pkg for its depth.
module flr_cmd_fifo #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0]             mem_r [flr_pkg::CMD_DEPTH];
  logic [flr_pkg::CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [flr_pkg::CMD_PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (flr_pkg::CMD_PTR_W+1)'(flr_pkg::CMD_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/flr_page_store.sv =====
// Packet word memory and per-slot fill counts, one write and one read port each.
// Depends on flr_pkg for page geometry.
module flr_page_store #(
  parameter int SLOTS  = 37,
  parameter int SLOT_W = 6
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [SLOT_W+flr_pkg::WORD_IDX_W-1:0] wr_addr,
  input  logic [31:0]                          wr_data,
  input  logic                                 fill_wr_en,
  input  logic [SLOT_W-1:0]                    fill_wr_slot,
  input  logic [flr_pkg::FILL_W-1:0]           fill_wr_val,
  input  logic                                 rd_en,
  input  logic [SLOT_W+flr_pkg::WORD_IDX_W-1:0] rd_addr,
  output logic [31:0]                          rd_data,
  input  logic                                 fill_rd_en,
  input  logic [SLOT_W-1:0]                    fill_rd_slot,
  output logic [flr_pkg::FILL_W-1:0]           fill_rd_val
);

  logic [31:0]                word_mem [SLOTS*flr_pkg::PAGE_WORDS];
  logic [flr_pkg::FILL_W-1:0] fill_mem [SLOTS];
  logic [31:0]                rd_data_r;
  logic [flr_pkg::FILL_W-1:0] fill_rd_r;

  assign rd_data     = rd_data_r;
  assign fill_rd_val = fill_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= word_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_wr_en) begin
      fill_mem[fill_wr_slot] <= fill_wr_val;
    end
    if (fill_rd_en) begin
      fill_rd_r <= fill_mem[fill_rd_slot];
    end
  end

endmodule

// ===== rtl/flr_front.sv =====
// Front of the recorder: takes items and config writes, runs the flash sequencer
// and packet queue bookkeeping, writes sample words, issues one request per item.
// Depends on flr_pkg.
module flr_front #(
  parameter int QUEUE_PACKETS = 32,
  parameter int SLOTS         = 37,
  parameter int SLOT_W        = 6,
  parameter int CNT_W         = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_func,
  input  logic                                 in_flash_busy,
  input  logic [31:0]                          in_sample_word,
  input  logic                                 in_end_of_packet,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [24:0]                          cfg_data,
  output logic                                 cmd_push,
  output flr_pkg::cmd_t                        cmd_data,
  output logic [SLOT_W-1:0]                    cmd_slot,
  input  logic                                 cmd_full,
  output logic                                 wr_en,
  output logic [SLOT_W+flr_pkg::WORD_IDX_W-1:0] wr_addr,
  output logic [31:0]                          wr_data,
  output logic                                 fill_wr_en,
  output logic [SLOT_W-1:0]                    fill_wr_slot,
  output logic [flr_pkg::FILL_W-1:0]           fill_wr_val
);

  logic [23:0]                fs_r;
  logic [24:0]                max_r;
  flr_pkg::phase_t            phase_r, phase_nxt;
  logic                       rec_r, rec_nxt;
  logic [24:0]                wa_r, wa_nxt;
  logic [24:0]                ea_r, ea_nxt;
  logic [SLOT_W-1:0]          head_r, head_nxt;
  logic [SLOT_W-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [flr_pkg::FILL_W-1:0] fill_r, fill_nxt;

  logic                       in_fire;
  logic                       decide;
  flr_pkg::func_t             func;
  flr_pkg::kind_t             kind;
  logic [23:0]                addr;
  flr_pkg::verdict_t          verdict;
  flr_pkg::state_code_t       state_code;
  logic [flr_pkg::SUM_W-1:0]  wa_ext, fs_ext;
  logic                       area_full, near_erase, q_full, fill_room;
  logic [flr_pkg::FILL_W-1:0] fill_inc;
  logic [SLOT_W-1:0]          head_inc, tail_inc;
  logic [24:0]                kb_diff;
  logic [CNT_W+5:0]           q_ext;

  assign func       = flr_pkg::func_t'(in_func);
  assign in_stall   = cmd_full;
  assign in_fire    = in_valid && !cmd_full;
  assign cfg_ready  = 1'b1;

  assign wa_ext     = {1'b0, wa_r};
  assign fs_ext     = {2'b00, fs_r};
  assign area_full  = wa_ext >= (fs_ext + {1'b0, max_r});
  assign near_erase = (wa_ext + flr_pkg::GUARD_BYTES) >= {1'b0, ea_r};
  assign q_full     = count_r >= CNT_W'(QUEUE_PACKETS);
  assign fill_room  = fill_r < flr_pkg::FILL_W'(flr_pkg::PAGE_WORDS);
  assign fill_inc   = fill_room ? fill_r + 1'b1 : fill_r;
  assign head_inc   = (head_r == SLOT_W'(SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == SLOT_W'(SLOTS - 1)) ? '0 : tail_r + 1'b1;

  assign wr_addr      = {tail_r, fill_r[flr_pkg::WORD_IDX_W-1:0]};
  assign wr_data      = in_sample_word;
  assign fill_wr_slot = tail_r;
  assign fill_wr_val  = fill_inc;

  always_comb begin
    phase_nxt  = phase_r;
    rec_nxt    = rec_r;
    wa_nxt     = wa_r;
    ea_nxt     = ea_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    fill_nxt   = fill_r;
    kind       = flr_pkg::KIND_NONE;
    addr       = '0;
    verdict    = flr_pkg::VERDICT_QUEUED;
    decide     = 1'b0;
    wr_en      = 1'b0;
    fill_wr_en = 1'b0;
    if (in_fire) begin
      case (func)
        flr_pkg::FN_TICK: begin
          case (phase_r)
            flr_pkg::PH_IDLE: begin
              if (rec_r) begin
                wa_nxt    = {1'b0, fs_r};
                kind      = flr_pkg::KIND_ERASE;
                addr      = fs_r;
                ea_nxt    = flr_pkg::sat_addr(fs_ext + flr_pkg::BLOCK_BYTES);
                head_nxt  = tail_r;
                count_nxt = '0;
                phase_nxt = flr_pkg::PH_WAIT;
              end
            end
            flr_pkg::PH_WAIT: begin
              if (!in_flash_busy) begin
                phase_nxt = flr_pkg::PH_DECIDE;
                decide    = 1'b1;
              end
            end
            flr_pkg::PH_DECIDE: decide = 1'b1;
            default: phase_nxt = flr_pkg::PH_IDLE;
          endcase
          if (decide) begin
            if (!rec_r) begin
              kind      = flr_pkg::KIND_STOPPED;
              phase_nxt = flr_pkg::PH_IDLE;
            end else if (area_full) begin
              rec_nxt   = 1'b0;
              kind      = flr_pkg::KIND_STOPPED;
              phase_nxt = flr_pkg::PH_IDLE;
            end else if (near_erase) begin
              kind      = flr_pkg::KIND_ERASE;
              addr      = ea_r[23:0];
              ea_nxt    = flr_pkg::sat_addr({1'b0, ea_r} + flr_pkg::BLOCK_BYTES);
              phase_nxt = flr_pkg::PH_WAIT;
            end else if (count_r != '0) begin
              kind      = flr_pkg::KIND_PROGRAM;
              addr      = wa_r[23:0];
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              wa_nxt    = flr_pkg::sat_addr(wa_ext + flr_pkg::PAGE_BYTES);
              phase_nxt = flr_pkg::PH_WAIT;
            end
          end
        end
        flr_pkg::FN_START: rec_nxt = 1'b1;
        flr_pkg::FN_STOP:  rec_nxt = 1'b0;
        flr_pkg::FN_PUSH: begin
          wr_en    = fill_room;
          fill_nxt = fill_inc;
          if (in_end_of_packet) begin
            kind     = flr_pkg::KIND_VERDICT;
            fill_nxt = '0;
            if (phase_r == flr_pkg::PH_IDLE) begin
              verdict = flr_pkg::VERDICT_NOT_RECORDING;
            end else if (q_full) begin
              verdict = flr_pkg::VERDICT_QUEUE_FULL;
            end else begin
              fill_wr_en = 1'b1;
              tail_nxt   = tail_inc;
              count_nxt  = count_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (phase_nxt == flr_pkg::PH_IDLE) begin
      state_code = flr_pkg::STATE_IDLE;
    end else if (rec_nxt) begin
      state_code = flr_pkg::STATE_RECORDING;
    end else begin
      state_code = flr_pkg::STATE_STOPPING;
    end
    kb_diff = wa_nxt - {1'b0, fs_r};
    q_ext   = {6'd0, count_nxt};
    cmd_data.kind           = kind;
    cmd_data.flash_address  = addr;
    cmd_data.verdict        = verdict;
    cmd_data.state_code     = state_code;
    cmd_data.recorded_kb    = (wa_nxt < {1'b0, fs_r}) ? 15'd0 : kb_diff[24:flr_pkg::KB_SHIFT];
    cmd_data.queued_packets = q_ext[5:0];
  end

  assign cmd_push = in_fire;
  assign cmd_slot = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r  <= '0;
      max_r <= flr_pkg::MAX_BYTES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        flr_pkg::REG_FLASH_START: fs_r  <= cfg_data[23:0];
        flr_pkg::REG_MAX_BYTES:   max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= flr_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r   <= 1'b0;
      wa_r    <= '0;
      ea_r    <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      fill_r  <= '0;
    end else begin
      rec_r   <= rec_nxt;
      wa_r    <= wa_nxt;
      ea_r    <= ea_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

// ===== rtl/flr_back.sv =====
// Back of the recorder: executes queued requests, streams page words out of
// the packet store and holds the result register. Depends on flr_pkg.
module flr_back #(
  parameter int SLOT_W = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_empty,
  output logic                                 cmd_pop,
  input  flr_pkg::cmd_t                        cmd_data,
  input  logic [SLOT_W-1:0]                    cmd_slot,
  output logic                                 rd_en,
  output logic [SLOT_W+flr_pkg::WORD_IDX_W-1:0] rd_addr,
  input  logic [31:0]                          rd_data,
  output logic                                 fill_rd_en,
  output logic [SLOT_W-1:0]                    fill_rd_slot,
  input  logic [flr_pkg::FILL_W-1:0]           fill_rd_val,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_kind,
  output logic [23:0]                          out_flash_address,
  output logic [31:0]                          out_program_word,
  output logic                                 out_last,
  output logic [1:0]                           out_verdict,
  output logic [1:0]                           out_state_code,
  output logic [14:0]                          out_recorded_kb,
  output logic [5:0]                           out_queued_packets
);

  flr_pkg::back_state_t            st_r, st_nxt;
  flr_pkg::cmd_t                   cmd_r, out_cmd_r;
  logic [SLOT_W-1:0]               slot_r;
  logic [flr_pkg::WORD_IDX_W-1:0]  idx_r, s1_idx_r;
  logic                            s1_v_r, out_v_r;
  logic [31:0]                     out_word_r;
  logic                            out_last_r;
  logic                            out_free, s1_move, single_load, pad;

  assign out_free     = !out_v_r || !out_stall;
  assign s1_move      = s1_v_r && out_free;
  assign rd_addr      = {slot_r, idx_r};
  assign fill_rd_slot = cmd_slot;
  assign pad          = {1'b0, s1_idx_r} >= fill_rd_val;

  always_comb begin
    st_nxt      = st_r;
    cmd_pop     = 1'b0;
    rd_en       = 1'b0;
    fill_rd_en  = 1'b0;
    single_load = 1'b0;
    case (st_r)
      flr_pkg::BK_IDLE: begin
        if (!cmd_empty && !s1_v_r) begin
          cmd_pop = 1'b1;
          if (cmd_data.kind == flr_pkg::KIND_PROGRAM) begin
            fill_rd_en = 1'b1;
            st_nxt     = flr_pkg::BK_PAGE;
          end else begin
            st_nxt = flr_pkg::BK_SINGLE;
          end
        end
      end
      flr_pkg::BK_SINGLE: begin
        if (out_free) begin
          single_load = 1'b1;
          st_nxt      = flr_pkg::BK_IDLE;
        end
      end
      flr_pkg::BK_PAGE: begin
        if (!s1_v_r || s1_move) begin
          rd_en = 1'b1;
          if (idx_r == flr_pkg::PAGE_LAST) begin
            st_nxt = flr_pkg::BK_IDLE;
          end
        end
      end
      default: st_nxt = flr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= flr_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (rd_en) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (single_load || s1_move) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cmd_pop) begin
        idx_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r  <= cmd_data;
      slot_r <= cmd_slot;
    end
    if (rd_en) begin
      s1_idx_r <= idx_r;
    end
    if (single_load) begin
      out_cmd_r  <= cmd_r;
      out_word_r <= '0;
      out_last_r <= 1'b1;
    end else if (s1_move) begin
      out_cmd_r  <= cmd_r;
      out_word_r <= pad ? 32'd0 : rd_data;
      out_last_r <= (s1_idx_r == flr_pkg::PAGE_LAST);
    end
  end

  assign out_valid          = out_v_r;
  assign out_kind           = out_cmd_r.kind;
  assign out_flash_address  = out_cmd_r.flash_address;
  assign out_program_word   = out_word_r;
  assign out_last           = out_last_r;
  assign out_verdict        = out_cmd_r.verdict;
  assign out_state_code     = out_cmd_r.state_code;
  assign out_recorded_kb    = out_cmd_r.recorded_kb;
  assign out_queued_packets = out_cmd_r.queued_packets;

endmodule

// ===== rtl/flash_stream_recorder_core.sv =====
// Flash stream recorder: front, request queue, packet store and back.
// Takes an item per cycle while the request queue has room; a single result
// goes through the queue, request and output registers; a page program gives 64
// results, one per cycle unless stalled, set by the store's single read port.
// Synchronous reset clears all control state; the packet store is not cleared.
module flash_stream_recorder_core #(
  parameter int QUEUE_PACKETS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_flash_busy,
  input  logic [31:0] in_sample_word,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [23:0] out_flash_address,
  output logic [31:0] out_program_word,
  output logic        out_last,
  output logic [1:0]  out_verdict,
  output logic [1:0]  out_state_code,
  output logic [14:0] out_recorded_kb,
  output logic [5:0]  out_queued_packets,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  localparam int SLOTS    = QUEUE_PACKETS + flr_pkg::CMD_DEPTH + 1;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(QUEUE_PACKETS + 1);
  localparam int CMD_BITS = $bits(flr_pkg::cmd_t);
  localparam int ADDR_W   = SLOT_W + flr_pkg::WORD_IDX_W;

  logic                       fifo_push, fifo_pop, fifo_full, fifo_empty;
  flr_pkg::cmd_t              push_cmd, pop_cmd;
  logic [SLOT_W-1:0]          push_slot, pop_slot;
  logic [CMD_BITS+SLOT_W-1:0] pop_data;

  logic                       wr_en, rd_en, fill_wr_en, fill_rd_en;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;
  logic [31:0]                wr_data, rd_data;
  logic [SLOT_W-1:0]          fill_wr_slot, fill_rd_slot;
  logic [flr_pkg::FILL_W-1:0] fill_wr_val, fill_rd_val;

  flr_front #(
    .QUEUE_PACKETS (QUEUE_PACKETS),
    .SLOTS         (SLOTS),
    .SLOT_W        (SLOT_W),
    .CNT_W         (CNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_flash_busy    (in_flash_busy),
    .in_sample_word   (in_sample_word),
    .in_end_of_packet (in_end_of_packet),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd_push         (fifo_push),
    .cmd_data         (push_cmd),
    .cmd_slot         (push_slot),
    .cmd_full         (fifo_full),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .fill_wr_en       (fill_wr_en),
    .fill_wr_slot     (fill_wr_slot),
    .fill_wr_val      (fill_wr_val)
  );

  flr_cmd_fifo #(
    .WIDTH (CMD_BITS + SLOT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data ({push_slot, push_cmd}),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  assign pop_cmd  = flr_pkg::cmd_t'(pop_data[CMD_BITS-1:0]);
  assign pop_slot = pop_data[CMD_BITS +: SLOT_W];

  flr_page_store #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .fill_wr_en   (fill_wr_en),
    .fill_wr_slot (fill_wr_slot),
    .fill_wr_val  (fill_wr_val),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .fill_rd_en   (fill_rd_en),
    .fill_rd_slot (fill_rd_slot),
    .fill_rd_val  (fill_rd_val)
  );

  flr_back #(
    .SLOT_W (SLOT_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_empty          (fifo_empty),
    .cmd_pop            (fifo_pop),
    .cmd_data           (pop_cmd),
    .cmd_slot           (pop_slot),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .fill_rd_en         (fill_rd_en),
    .fill_rd_slot       (fill_rd_slot),
    .fill_rd_val        (fill_rd_val),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_flash_address  (out_flash_address),
    .out_program_word   (out_program_word),
    .out_last           (out_last),
    .out_verdict        (out_verdict),
    .out_state_code     (out_state_code),
    .out_recorded_kb    (out_recorded_kb),
    .out_queued_packets (out_queued_packets)
  );

  a_no_push_when_full: assert property (
    @(posedge clk) disable iff (!rst_n) fifo_full |-> !fifo_push
  ) else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (
    @(posedge clk) disable iff (!rst_n) fifo_pop |-> !fifo_empty
  ) else $error("request popped from an empty queue");

  a_single_is_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != flr_pkg::KIND_PROGRAM)) |-> out_last
  ) else $error("non-program result not marked last");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of flash_stream_recorder_core: a scoreboard class
// predicts every result of each accepted request and compares the results.
// Depends on flr_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
  import flr_pkg::*;

  localparam int QUEUE_SLOTS = 32;
  localparam int RANDOM_REQUESTS = 230;
  localparam int LONG_RUN_PAGES = 262;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int FINAL_CYCLES = 16;
  localparam logic [1:0] REG_UNMAPPED = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] flash_address;
    logic [31:0] program_word;
    logic        last;
    verdict_t    verdict;
    state_code_t state_code;
    logic [14:0] recorded_kb;
    logic [5:0]  queued_packets;
  } flash_result_t;

  class flash_recorder_model;
    flash_result_t expected_q[$];
    flash_result_t batch[$];
    int errors = 0;
    int unsigned area_start = 0;
    int unsigned area_bytes = MAX_BYTES_RESET;
    phase_t seq_phase = PH_IDLE;
    bit recording = 1'b0;
    int unsigned write_addr = 0;
    int unsigned erase_addr = 0;
    logic [31:0] page_store [QUEUE_SLOTS*PAGE_WORDS];
    logic [31:0] fill_buf [PAGE_WORDS];
    int unsigned q_head = 0;
    int unsigned q_tail = 0;
    int unsigned q_count = 0;
    int unsigned fill_count = 0;

    function int unsigned clamp_addr(int unsigned v);
      return (v > ADDR_LIMIT) ? ADDR_LIMIT : v;
    endfunction

    function void emit(kind_t kind, int unsigned addr, logic [31:0] word, verdict_t verdict);
      flash_result_t r;
      r = '0;
      r.kind = kind;
      r.flash_address = addr[23:0];
      r.program_word = word;
      r.verdict = verdict;
      batch.push_back(r);
    endfunction

    function void configure(logic [1:0] index, logic [24:0] data);
      case (index)
        REG_FLASH_START: area_start = data[23:0];
        REG_MAX_BYTES:   area_bytes = data;
        default: ;
      endcase
    endfunction

    function void advance_flash(logic busy);
      if (seq_phase == PH_IDLE) begin
        if (!recording) return;
        write_addr = area_start;
        emit(KIND_ERASE, area_start, '0, VERDICT_QUEUED);
        erase_addr = clamp_addr(area_start + BLOCK_BYTES);
        q_head = 0;
        q_tail = 0;
        q_count = 0;
        seq_phase = PH_WAIT;
        return;
      end
      if (seq_phase == PH_WAIT) begin
        if (busy) return;
        seq_phase = PH_DECIDE;
      end
      if (!recording || write_addr >= area_start + area_bytes) begin
        recording = 1'b0;
        emit(KIND_STOPPED, 0, '0, VERDICT_QUEUED);
        seq_phase = PH_IDLE;
      end else if (write_addr + GUARD_BYTES >= erase_addr) begin
        emit(KIND_ERASE, erase_addr, '0, VERDICT_QUEUED);
        erase_addr = clamp_addr(erase_addr + BLOCK_BYTES);
        seq_phase = PH_WAIT;
      end else if (q_count > 0) begin
        for (int i = 0; i < PAGE_WORDS; i++) begin
          emit(KIND_PROGRAM, write_addr, page_store[q_head*PAGE_WORDS + i], VERDICT_QUEUED);
        end
        q_head = (q_head + 1) % QUEUE_SLOTS;
        q_count--;
        write_addr = clamp_addr(write_addr + PAGE_BYTES);
        seq_phase = PH_WAIT;
      end
    endfunction

    function void collect_page(logic [31:0] word, logic eop);
      verdict_t v;
      if (fill_count < PAGE_WORDS) begin
        fill_buf[fill_count] = word;
        fill_count++;
      end
      if (!eop) return;
      if (seq_phase == PH_IDLE) begin
        v = VERDICT_NOT_RECORDING;
      end else if (q_count >= QUEUE_SLOTS) begin
        v = VERDICT_QUEUE_FULL;
      end else begin
        for (int i = 0; i < PAGE_WORDS; i++) begin
          page_store[q_tail*PAGE_WORDS + i] = (i < fill_count) ? fill_buf[i] : '0;
        end
        q_tail = (q_tail + 1) % QUEUE_SLOTS;
        q_count++;
        v = VERDICT_QUEUED;
      end
      fill_count = 0;
      emit(KIND_VERDICT, 0, '0, v);
    endfunction

    function void predict_request(func_t fn, logic busy, logic [31:0] word, logic eop);
      state_code_t code;
      logic [14:0] kb;
      flash_result_t r;
      batch.delete();
      case (fn)
        FN_TICK:  advance_flash(busy);
        FN_START: recording = 1'b1;
        FN_STOP:  recording = 1'b0;
        default:  collect_page(word, eop);
      endcase
      if (batch.size() == 0) emit(KIND_NONE, 0, '0, VERDICT_QUEUED);
      if (seq_phase == PH_IDLE) code = STATE_IDLE;
      else if (recording) code = STATE_RECORDING;
      else code = STATE_STOPPING;
      kb = (write_addr < area_start) ? '0 : 15'((write_addr - area_start) >> KB_SHIFT);
      foreach (batch[k]) begin
        r = batch[k];
        r.last = (k == batch.size() - 1);
        r.state_code = code;
        r.recorded_kb = kb;
        r.queued_packets = q_count[5:0];
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0h, got %0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(flash_result_t got);
      flash_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d", got.kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("flash_address", want.flash_address, got.flash_address);
      compare_field("program_word", want.program_word, got.program_word);
      compare_field("last", want.last, got.last);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("state_code", want.state_code, got.state_code);
      compare_field("recorded_kb", want.recorded_kb, got.recorded_kb);
      compare_field("queued_packets", want.queued_packets, got.queued_packets);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic        in_flash_busy = 1'b0;
  logic [31:0] in_sample_word = '0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [23:0] out_flash_address;
  logic [31:0] out_program_word;
  logic        out_last;
  logic [1:0]  out_verdict;
  logic [1:0]  out_state_code;
  logic [14:0] out_recorded_kb;
  logic [5:0]  out_queued_packets;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  flash_recorder_model model;
  flash_result_t seen_result;
  bit calm = 1'b0;
  int requests_sent = 0;
  int quiet_cycles = 0;

  assign seen_result = {out_kind, out_flash_address, out_program_word, out_last,
                        out_verdict, out_state_code, out_recorded_kb, out_queued_packets};

  flash_stream_recorder_core #(
    .QUEUE_PACKETS(QUEUE_SLOTS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_flash_busy(in_flash_busy),
    .in_sample_word(in_sample_word),
    .in_end_of_packet(in_end_of_packet),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_flash_address(out_flash_address),
    .out_program_word(out_program_word),
    .out_last(out_last),
    .out_verdict(out_verdict),
    .out_state_code(out_state_code),
    .out_recorded_kb(out_recorded_kb),
    .out_queued_packets(out_queued_packets),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) model.check_result(seen_result);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(func_t fn, logic busy, logic [31:0] word, logic eop);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_flash_busy <= busy;
    in_sample_word <= word;
    in_end_of_packet <= eop;
    do @(posedge clk); while (in_stall);
    model.predict_request(fn, busy, word, eop);
    requests_sent++;
  endtask

  task automatic issue_tick(logic busy);
    send_request(FN_TICK, busy, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic issue_command(func_t fn);
    send_request(fn, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
  endtask

  task automatic push_packet(int len);
    for (int i = 0; i < len; i++) begin
      send_request(FN_PUSH, 1'($urandom_range(1)), $urandom, i == len - 1);
    end
  endtask

  task automatic write_register(logic [1:0] index, logic [24:0] data);
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model.configure(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (model.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 64);
    return $urandom_range(65, 70);
  endfunction

  function automatic logic [23:0] pick_start();
    case ($urandom_range(3))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return {8'($urandom_range(255)), 16'h0};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [24:0] pick_bytes();
    case ($urandom_range(3))
      0: return '0;
      1: return 25'd16777216;
      2: return 25'(256 * $urandom_range(1, 40));
      default: return 25'($urandom_range(0, 16777216));
    endcase
  endfunction

  task automatic run_session();
    int action;
    issue_command(FN_START);
    issue_tick(1'($urandom_range(1)));
    repeat ($urandom_range(8, 20)) begin
      action = $urandom_range(99);
      if (action < 40) begin
        push_packet(pick_length());
      end else if (action < 75) begin
        issue_tick($urandom_range(3) == 0);
      end else if (action < 80) begin
        repeat ($urandom_range(30, 36)) push_packet(1);
      end else if (action < 85) begin
        issue_command(FN_START);
      end else if (action < 90) begin
        issue_command(FN_STOP);
      end else begin
        send_request(func_t'($urandom_range(3)), 1'($urandom_range(1)), $urandom,
                     1'($urandom_range(1)));
      end
    end
    issue_command(FN_STOP);
    issue_tick(1'b0);
    issue_tick(1'b0);
  endtask

  task automatic run_long_recording();
    issue_command(FN_START);
    issue_tick(1'b1);
    repeat (LONG_RUN_PAGES) begin
      push_packet(1);
      if ($urandom_range(7) == 0) issue_tick(1'b1);
      issue_tick(1'b0);
    end
    issue_command(FN_STOP);
    issue_tick(1'b0);
  endtask

  initial begin
    int random_base;
    model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_register(REG_FLASH_START, '0);
    write_register(REG_MAX_BYTES, 25'd768);
    write_register(REG_UNMAPPED, 25'h1FFFFFF);
    issue_tick(1'b0);
    send_request(FN_PUSH, 1'b0, 32'hFFFFFFFF, 1'b1);
    issue_command(FN_START);
    send_request(FN_PUSH, 1'b1, 32'h00000000, 1'b1);
    issue_command(FN_START);
    issue_tick(1'b1);
    issue_tick(1'b1);
    issue_tick(1'b0);
    send_request(FN_PUSH, 1'b0, 32'hFFFFFFFF, 1'b0);
    send_request(FN_PUSH, 1'b1, 32'h80000001, 1'b1);
    issue_tick(1'b0);
    issue_tick(1'b0);
    issue_command(FN_STOP);
    issue_tick(1'b1);
    settle();
    write_register(REG_MAX_BYTES, '0);
    issue_command(FN_START);
    issue_tick(1'b0);
    issue_tick(1'b0);

    settle();
    write_register(REG_FLASH_START, 24'hFFFFFF);
    write_register(REG_MAX_BYTES, 25'd16777216);
    random_base = requests_sent;
    run_session();
    while (requests_sent - random_base < RANDOM_REQUESTS) begin
      settle();
      write_register(REG_FLASH_START, pick_start());
      write_register(REG_MAX_BYTES, pick_bytes());
      if ($urandom_range(3) == 0) begin
        write_register(REG_UNMAPPED + 2'($urandom_range(1)), 25'($urandom));
      end
      run_session();
    end

    settle();
    calm = 1'b1;
    write_register(REG_FLASH_START, 24'hFF0000);
    write_register(REG_MAX_BYTES, 25'd16777216);
    run_long_recording();

    in_valid <= 1'b0;
    while (model.expected_q.size() != 0) @(posedge clk);
    repeat (FINAL_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
